[src/lkv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear key/value table package
// Opcodes, result status codes, the command word passed from the front end to
// the execution engine, and the engine state type.
// ----------------------------------------------------------------------------
package lkv_pkg;

  // Field widths fixed by the transaction format.
  localparam int KEY_W   = 64;
  localparam int VALUE_W = 32;
  localparam int SLOT_W  = 5;

  // Most results a single iterate transaction may produce.
  localparam int MAX_RESULTS = 32;

  typedef enum logic [1:0] {
    OP_PUT     = 2'd0,
    OP_GET     = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_ITERATE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // Command word held in the queue between front end and engine.
  typedef struct packed {
    opcode_t              op;
    logic                 lookup;  // Needs a key search (all but iterate).
    logic [KEY_W-1:0]     key;     // Already masked to the key length.
    logic [VALUE_W-1:0]   value;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_SCAN
  } bk_state_t;

endpackage

[src/lkv_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear key/value table channel interfaces
// Request channel (opcode, key, value) and result channel (status, slot, key,
// value, last), each with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lkv_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] key;
  logic [31:0] value;

  modport source (output valid, output opcode, output key, output value, input ready);
  modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

interface lkv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [4:0]  slot;
  logic [63:0] out_key;
  logic [31:0] out_value;
  logic        last;

  modport source (output valid, output status, output slot, output out_key,
                  output out_value, output last, input ready);
  modport sink   (input valid, input status, input slot, input out_key,
                  input out_value, input last, output ready);
endinterface

[src/lkv_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear key/value table front end
// Accepts request transactions, masks the key to its configured length and
// classifies the opcode into a command word for the queue.
// ----------------------------------------------------------------------------
module lkv_front #(
  parameter int KEY_BYTES = 8
) (
  lkv_in_if.sink          in_ch,
  input  logic            q_full,
  output logic            push,
  output lkv_pkg::cmd_t   push_cmd
);

  // Key bytes above the configured length are dropped.
  localparam logic [lkv_pkg::KEY_W-1:0] KEY_MASK =
    {lkv_pkg::KEY_W{1'b1}} >> (lkv_pkg::KEY_W - 8 * KEY_BYTES);

  lkv_pkg::opcode_t op;

  assign op          = lkv_pkg::opcode_t'(in_ch.opcode);
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  // Build the command word.
  always_comb begin
    push_cmd.op     = op;
    push_cmd.lookup = (op != lkv_pkg::OP_ITERATE);
    push_cmd.key    = in_ch.key & KEY_MASK;
    push_cmd.value  = in_ch.value;
  end

endmodule

[src/lkv_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear key/value table command queue
// Two-entry FIFO that decouples the front end from the execution engine.
// ----------------------------------------------------------------------------
module lkv_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lkv_pkg::cmd_t   push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output lkv_pkg::cmd_t   pop_cmd
);

  lkv_pkg::cmd_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_cmd   = entry_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[src/lkv_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear key/value table execution engine
// Holds the slot stores, compares a command key against all live slots in
// parallel, performs put/get/remove, walks live slots for iterate and drives
// the registered result channel.
// ----------------------------------------------------------------------------
module lkv_back #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_vld,
  input  lkv_pkg::cmd_t   q_cmd,
  output logic            q_pop,
  lkv_out_if.source       out_ch
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int HW_W  = $clog2(TABLE_DEPTH + 1);
  localparam int CNT_W = $clog2(lkv_pkg::MAX_RESULTS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(lkv_pkg::MAX_RESULTS - 1);

  // Lowest set bit of a slot vector.
  function automatic logic [IDX_W-1:0] first_one(input logic [TABLE_DEPTH-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

  lkv_pkg::bk_state_t state_r, state_nxt;

  lkv_pkg::cmd_t           cmd_r, cmd_nxt;
  logic                    mt_any_r, mt_any_nxt;
  logic [IDX_W-1:0]        mt_idx_r, mt_idx_nxt;
  logic [TABLE_DEPTH-1:0]  present_r, present_nxt;
  logic [HW_W-1:0]         hw_r, hw_nxt;
  logic [TABLE_DEPTH-1:0]  pend_r, pend_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;

  // Key store is in flops so every slot can be compared at once.
  logic [lkv_pkg::KEY_W-1:0]   key_mem [TABLE_DEPTH];
  logic [lkv_pkg::VALUE_W-1:0] val_mem [TABLE_DEPTH];
  logic [lkv_pkg::VALUE_W-1:0] val_rd_r;

  logic                    key_we, val_we;
  logic [IDX_W-1:0]        wr_idx, rd_idx;

  logic [TABLE_DEPTH-1:0]  below_hw, live, free_vec, key_eq, pend_clr;
  logic [IDX_W-1:0]        s_idx;
  logic                    scan_last, out_free, load_out;

  logic                    out_vld_r;
  lkv_pkg::status_t        o_status, status_r;
  logic [lkv_pkg::SLOT_W-1:0]  o_slot, slot_r;
  logic [lkv_pkg::KEY_W-1:0]   o_key, key_r;
  logic [lkv_pkg::VALUE_W-1:0] o_value, value_r;
  logic                    o_last, last_r;

  // Slot classification and parallel key compare.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      below_hw[i] = (HW_W'(i) < hw_r);
      key_eq[i]   = q_cmd.lookup && present_r[i] && below_hw[i] &&
                    (key_mem[i] == q_cmd.key);
    end
    live     = present_r & below_hw;
    free_vec = ~present_r & below_hw;
  end

  // Iterate walk: current slot and what remains after it.
  always_comb begin
    s_idx     = first_one(pend_r);
    pend_clr  = pend_r & ~(TABLE_DEPTH'(1) << s_idx);
    scan_last = (pend_clr == '0) || (cnt_r == CNT_LAST);
  end

  assign out_free = !out_vld_r || out_ch.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lkv_pkg::BK_IDLE: begin
        if (q_vld) begin
          state_nxt = lkv_pkg::BK_EXEC;
        end
      end
      lkv_pkg::BK_EXEC: begin
        if (out_free) begin
          if (cmd_r.op == lkv_pkg::OP_ITERATE && live != '0) begin
            state_nxt = lkv_pkg::BK_SCAN;
          end else begin
            state_nxt = lkv_pkg::BK_IDLE;
          end
        end
      end
      lkv_pkg::BK_SCAN: begin
        if (out_free && scan_last) begin
          state_nxt = lkv_pkg::BK_IDLE;
        end
      end
      default: state_nxt = lkv_pkg::BK_IDLE;
    endcase
  end

  // State-dependent datapath control and result formation.
  always_comb begin
    q_pop       = 1'b0;
    cmd_nxt     = cmd_r;
    mt_any_nxt  = mt_any_r;
    mt_idx_nxt  = mt_idx_r;
    present_nxt = present_r;
    hw_nxt      = hw_r;
    pend_nxt    = pend_r;
    cnt_nxt     = cnt_r;
    key_we      = 1'b0;
    val_we      = 1'b0;
    wr_idx      = mt_idx_r;
    rd_idx      = mt_idx_r;
    load_out    = 1'b0;
    o_status    = lkv_pkg::ST_OK;
    o_slot      = '0;
    o_key       = cmd_r.key;
    o_value     = '0;
    o_last      = 1'b1;
    unique case (state_r)
      lkv_pkg::BK_IDLE: begin
        // Take the next command and register its match result.
        if (q_vld) begin
          q_pop      = 1'b1;
          cmd_nxt    = q_cmd;
          mt_any_nxt = |key_eq;
          mt_idx_nxt = first_one(key_eq);
          rd_idx     = first_one(key_eq);
        end
      end
      lkv_pkg::BK_EXEC: begin
        if (out_free) begin
          load_out = 1'b1;
          unique case (cmd_r.op) inside
            lkv_pkg::OP_PUT: begin
              if (mt_any_r) begin
                val_we = 1'b1;
                wr_idx = mt_idx_r;
              end else if (free_vec != '0) begin
                key_we = 1'b1;
                val_we = 1'b1;
                wr_idx = first_one(free_vec);
                present_nxt[wr_idx] = 1'b1;
              end else if (hw_r < HW_W'(TABLE_DEPTH)) begin
                key_we = 1'b1;
                val_we = 1'b1;
                wr_idx = hw_r[IDX_W-1:0];
                present_nxt[wr_idx] = 1'b1;
                hw_nxt = hw_r + HW_W'(1);
              end else begin
                o_status = lkv_pkg::ST_FULL;
              end
              if (val_we) begin
                o_slot  = lkv_pkg::SLOT_W'(wr_idx);
                o_value = cmd_r.value;
              end
            end
            lkv_pkg::OP_GET, lkv_pkg::OP_REMOVE: begin
              if (mt_any_r) begin
                o_slot  = lkv_pkg::SLOT_W'(mt_idx_r);
                o_value = val_rd_r;
                if (cmd_r.op == lkv_pkg::OP_REMOVE) begin
                  present_nxt[mt_idx_r] = 1'b0;
                end
              end else begin
                o_status = lkv_pkg::ST_NOT_FOUND;
              end
            end
            lkv_pkg::OP_ITERATE: begin
              if (live == '0) begin
                o_status = lkv_pkg::ST_NOT_FOUND;
              end else begin
                // Start the walk and prefetch the first value.
                load_out = 1'b0;
                pend_nxt = live;
                cnt_nxt  = '0;
                rd_idx   = first_one(live);
              end
            end
            default: o_status = lkv_pkg::ST_NOT_FOUND;
          endcase
        end
      end
      lkv_pkg::BK_SCAN: begin
        rd_idx = s_idx;
        if (out_free) begin
          load_out = 1'b1;
          o_slot   = lkv_pkg::SLOT_W'(s_idx);
          o_key    = key_mem[s_idx];
          o_value  = val_rd_r;
          o_last   = scan_last;
          pend_nxt = pend_clr;
          cnt_nxt  = cnt_r + CNT_W'(1);
          rd_idx   = first_one(pend_clr);
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lkv_pkg::BK_IDLE;
      present_r <= '0;
      hw_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      present_r <= present_nxt;
      hw_r      <= hw_nxt;
      if (load_out) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Command and walk registers.
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    mt_any_r <= mt_any_nxt;
    mt_idx_r <= mt_idx_nxt;
    pend_r   <= pend_nxt;
    cnt_r    <= cnt_nxt;
  end

  // Slot stores; the value store has a registered read port.
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_idx] <= cmd_r.key;
    end
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[wr_idx] <= cmd_r.value;
    end
    val_rd_r <= val_mem[rd_idx];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      status_r <= o_status;
      slot_r   <= o_slot;
      key_r    <= o_key;
      value_r  <= o_value;
      last_r   <= o_last;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.status    = status_r;
  assign out_ch.slot      = slot_r;
  assign out_ch.out_key   = key_r;
  assign out_ch.out_value = value_r;
  assign out_ch.last      = last_r;

endmodule

[src/linear_key_value_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear key/value table
// Fixed table of key/value slots with put, get, remove and iterate, searched
// by a parallel compare of the request key against every live slot.
//
//   Channel   Dir   Handshake      Payload
//   in_ch     in    valid/ready    opcode, key, value
//   out_ch    out   valid/ready    status, slot, out_key, out_value, last
//
// In the engine, put, get and remove first do the parallel key compare, then
// update the stores and load the result register once it is free.
// Iterate reports each live entry as its own result (at most 32).
// A two-entry queue lets requests be taken while the engine or the result
// register is stalled. Reset is synchronous and clears the present marks and
// the high-water mark at once; no clearing pass follows.
// ----------------------------------------------------------------------------
module linear_key_value_table #(
  parameter int TABLE_DEPTH = 32,
  parameter int KEY_BYTES   = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  lkv_in_if.sink     in_ch,
  lkv_out_if.source  out_ch
);

  logic          push, q_full, q_pop, q_vld;
  lkv_pkg::cmd_t push_cmd, pop_cmd;

  lkv_front #(
    .KEY_BYTES (KEY_BYTES)
  ) u_front (
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  lkv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_vld),
    .pop_cmd   (pop_cmd)
  );

  lkv_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_vld  (q_vld),
    .q_cmd  (pop_cmd),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule
